FILE: src/tcrf_pkg.sv
// ----------------------------------------------------------------------------
// tcrf_pkg
// Shared types and constants of the thruster command receiver with failsafe.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrf_pkg;

	// channel count default
	localparam int unsigned CHANNELS_DEF = 8;

	// frame bytes
	localparam logic [7:0] HEADER_BYTE  = 8'hFF;
	localparam logic [7:0] TRAILER_BYTE = 8'hAA;
	localparam logic [7:0] NEUTRAL_CMD  = 8'h80;

	// pulse mapping
	localparam logic signed [13:0] PULSE_CENTER = 14'sd1500;
	localparam logic signed [13:0] CMD_OFFSET   = 14'sd128;
	localparam logic signed [13:0] PULSE_GAIN   = 14'sd25;
	localparam logic signed [13:0] PULSE_DIV    = 14'sd8;

	// duty = floor((82 * pulse + 6500) / 100), division by reciprocal
	localparam logic [6:0]  DUTY_GAIN   = 7'd82;
	localparam logic [18:0] DUTY_OFFSET = 19'd6500;
	localparam int unsigned RECIP_SHIFT = 25;
	localparam logic [18:0] RECIP_100   = 19'((2 ** RECIP_SHIFT + 99) / 100);

	// register reset values
	localparam logic [7:0]  DIR_MASK_RST  = 8'hFF;
	localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
	localparam logic [11:0] PULSE_MIN_RST = 12'd1100;
	localparam logic [11:0] PULSE_MAX_RST = 12'd1900;

	// register indexes
	typedef enum logic [7:0] {
		REG_DIR_MASK  = 8'd0,
		REG_TIMEOUT   = 8'd1,
		REG_PULSE_MIN = 8'd2,
		REG_PULSE_MAX = 8'd3
	} reg_idx_t;

	// input kinds
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// result causes
	typedef enum logic {
		CAUSE_FRAME   = 1'b0,
		CAUSE_TIMEOUT = 1'b1
	} cause_t;

	// one channel beat handed to the duty pipeline
	typedef struct packed {
		logic       fwd;
		logic [2:0] chan;
		logic [7:0] cmd;
		cause_t     cause;
		logic       last;
	} beat_t;

endpackage

`default_nettype wire

FILE: src/thruster_command_receiver_failsafe.sv
// Path: the byte or tick that causes a run sets issuing_q; each result beat then
// passes the memory read stage and the s2, s3 and output registers; the run
// gives one result per cycle while the output takes it.
// Input hold: a beat that causes results holds the input until the run has
// read the command memory once per channel; other beats do not hold it.
// Reset: asynchronous, registers to their defaults, framer hunting for a
// header, silence counter and timeout flag cleared.
// ----------------------------------------------------------------------------
// thruster_command_receiver_failsafe
// Frames UART bytes into channel commands, watches for silence and emits
// per-channel PWM duty values on a good frame or on failsafe timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module thruster_command_receiver_failsafe #(
	parameter int unsigned CHANNELS = tcrf_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // rx_byte
	input  wire logic        s_axis_tuser,   // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // channel[2:0], command_value[10:3], duty[24:11]
	output logic             m_axis_tuser,   // cause
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned POS_W = $clog2(CHANNELS + 2);
	localparam int unsigned CX_W  = (CH_W > 3) ? CH_W : 4;

	// configuration registers
	logic [7:0]  dir_mask_q;
	logic [15:0] timeout_q;
	logic [11:0] pulse_min_q, pulse_max_q;

	// framer and silence state
	logic [POS_W-1:0] pos_q;
	logic [15:0]      silence_q;
	logic             timed_out_q;
	logic [15:0]      silence_inc;

	// run issue state
	logic                issuing_q;
	logic [CH_W-1:0]     iss_ch_q;
	tcrf_pkg::cause_t    iss_cause_q;
	logic [CX_W-1:0]     iss_ch_x;
	logic                iss_fwd;

	// pending command memory
	logic [7:0]          cmd_mem [CHANNELS];
	logic                mem_we;
	logic [CH_W-1:0]     mem_wa;

	// stage one
	logic                valid_s1;
	logic [7:0]          rdata_s1;
	tcrf_pkg::beat_t     beat_s1, beat_in;
	logic                duty_ready;

	logic                in_fire, is_tick, is_byte;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !issuing_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign is_tick       = in_fire && (s_axis_tuser == tcrf_pkg::KIND_TICK);
	assign is_byte       = in_fire && (s_axis_tuser == tcrf_pkg::KIND_BYTE);
	assign silence_inc   = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_mask_q  <= tcrf_pkg::DIR_MASK_RST;
			timeout_q   <= tcrf_pkg::TIMEOUT_RST;
			pulse_min_q <= tcrf_pkg::PULSE_MIN_RST;
			pulse_max_q <= tcrf_pkg::PULSE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcrf_pkg::REG_DIR_MASK:  dir_mask_q  <= cfg_data[7:0];
				tcrf_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data;
				tcrf_pkg::REG_PULSE_MIN: pulse_min_q <= cfg_data[11:0];
				tcrf_pkg::REG_PULSE_MAX: pulse_max_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// command bytes land in the memory at their frame slot
	assign mem_we = is_byte && (pos_q != '0) && (pos_q <= POS_W'(CHANNELS));
	assign mem_wa = CH_W'(pos_q - POS_W'(1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cmd_mem[mem_wa] <= s_axis_tdata;
		end
	end

	// framer, silence counter and run start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			silence_q   <= '0;
			timed_out_q <= 1'b0;
			issuing_q   <= 1'b0;
			iss_ch_q    <= '0;
			iss_cause_q <= tcrf_pkg::CAUSE_FRAME;
		end else begin
			if (is_tick) begin
				silence_q <= silence_inc;
				if (!timed_out_q && (silence_inc >= timeout_q)) begin
					timed_out_q <= 1'b1;
					issuing_q   <= 1'b1;
					iss_ch_q    <= '0;
					iss_cause_q <= tcrf_pkg::CAUSE_TIMEOUT;
				end
			end else if (is_byte) begin
				priority if (pos_q == '0) begin
					if (s_axis_tdata == tcrf_pkg::HEADER_BYTE) begin
						pos_q <= POS_W'(1);
					end
				end else if (pos_q <= POS_W'(CHANNELS)) begin
					pos_q <= pos_q + POS_W'(1);
				end else begin
					pos_q <= '0;
					if (s_axis_tdata == tcrf_pkg::TRAILER_BYTE) begin
						silence_q   <= '0;
						timed_out_q <= 1'b0;
						issuing_q   <= 1'b1;
						iss_ch_q    <= '0;
						iss_cause_q <= tcrf_pkg::CAUSE_FRAME;
					end
				end
			end else if (issuing_q && duty_ready) begin
				// one channel read per cycle while the duty pipeline is ready
				if (iss_ch_q == CH_W'(CHANNELS - 1)) begin
					issuing_q <= 1'b0;
				end else begin
					iss_ch_q <= iss_ch_q + CH_W'(1);
				end
			end
		end
	end

	// direction bit, channels past the mask run forward
	assign iss_ch_x = CX_W'(iss_ch_q);
	assign iss_fwd  = (iss_ch_x < CX_W'(8)) ? dir_mask_q[iss_ch_x[2:0]] : 1'b1;

	// stage one: registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (duty_ready) begin
			valid_s1 <= issuing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (duty_ready) begin
			rdata_s1      <= cmd_mem[iss_ch_q];
			beat_s1.fwd   <= iss_fwd;
			beat_s1.chan  <= 3'(iss_ch_q);
			beat_s1.cmd   <= '0;
			beat_s1.cause <= iss_cause_q;
			beat_s1.last  <= (iss_ch_q == CH_W'(CHANNELS - 1));
		end
	end

	// failsafe runs carry the neutral command
	always_comb begin
		beat_in     = beat_s1;
		beat_in.cmd = (beat_s1.cause == tcrf_pkg::CAUSE_TIMEOUT) ? tcrf_pkg::NEUTRAL_CMD
		                                                         : rdata_s1;
	end

	tcrf_duty u_duty (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1),
		.in_ready      (duty_ready),
		.in_beat       (beat_in),
		.pulse_min     (pulse_min_q),
		.pulse_max     (pulse_max_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: src/tcrf_duty.sv
// ----------------------------------------------------------------------------
// tcrf_duty
// Pipeline from command byte to clamped pulse and PWM duty, with output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrf_duty (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tcrf_pkg::beat_t in_beat,
	input  wire logic [11:0]     pulse_min,
	input  wire logic [11:0]     pulse_max,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // channel[2:0], command_value[10:3], duty[24:11]
	output logic                 m_axis_tuser,  // cause
	output logic                 m_axis_tlast
);

	logic            adv;
	logic            valid_s2, valid_s3, out_valid_q;
	tcrf_pkg::beat_t beat_s2, beat_s3, beat_q;
	logic [11:0]     pulse_s2;
	logic [18:0]     x_s3;
	logic [13:0]     duty_q;

	logic signed [13:0] diff, prod, quot, raw, lo_c;
	logic [11:0]        clamped;
	logic [18:0]        x_d;
	logic [38:0]        recip;

	// whole pipeline moves when the output slot frees
	assign adv      = !out_valid_q || m_axis_tready;
	assign in_ready = adv;

	// signed pulse offset, truncated toward zero
	always_comb begin
		diff = $signed({6'd0, in_beat.cmd}) - tcrf_pkg::CMD_OFFSET;
		prod = diff * tcrf_pkg::PULSE_GAIN;
		if (!in_beat.fwd) begin
			prod = -prod;
		end
		quot = prod / tcrf_pkg::PULSE_DIV;
		raw  = tcrf_pkg::PULSE_CENTER + quot;
		lo_c = (raw < $signed({2'd0, pulse_min})) ? $signed({2'd0, pulse_min}) : raw;
		clamped = (lo_c > $signed({2'd0, pulse_max})) ? pulse_max : lo_c[11:0];
	end

	// affine step of the duty
	assign x_d = 19'(pulse_s2) * 19'(tcrf_pkg::DUTY_GAIN) + tcrf_pkg::DUTY_OFFSET;

	// divide by 100 through the reciprocal
	assign recip = 39'(x_s3) * 39'(tcrf_pkg::RECIP_100);

	// stage registers and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= in_valid;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s2  <= in_beat;
			pulse_s2 <= clamped;
			beat_s3  <= beat_s2;
			x_s3     <= x_d;
			beat_q   <= beat_s3;
			duty_q   <= recip[tcrf_pkg::RECIP_SHIFT +: 14];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, duty_q, beat_q.cmd, beat_q.chan};
	assign m_axis_tuser  = beat_q.cause;
	assign m_axis_tlast  = beat_q.last;

endmodule

`default_nettype wire
